/* hw/rtl/assert_macros.svh */
// assertion macros shared by the smoother rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define MCAS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// expression must never be true outside reset
`define MCAS_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("forbidden condition seen");

`endif

/* hw/rtl/mcas_pkg.sv */
// shared types and constants of the mouth corner asymmetry smoother
// no dependencies
package mcas_pkg;

  localparam int CoordW        = 16;
  localparam int DefCoordWidth = 16;
  localparam int IntW          = 15;
  localparam int AsymW         = 16;
  localparam int InDataW       = 48;
  localparam int OutDataW      = 32;
  localparam int CfgAddrW      = 3;
  localparam int CfgDataW      = 16;
  localparam int MulW          = 18;
  localparam int ProdW         = 36;
  localparam int DivSteps      = 8;
  localparam int DivCntW       = $clog2(DivSteps);
  localparam int DecayShift    = 19;

  localparam logic [CoordW-1:0] GainReset  = 16'd13107;
  localparam logic [CoordW-1:0] LimitReset = 16'd4915;
  localparam logic [CoordW-1:0] DistMin    = 16'd16;
  localparam logic [IntW-1:0]   RiseSat    = 15'h7fff;
  localparam logic [AsymW-1:0]  AsymSat    = 16'h8000;
  localparam logic [MulW-1:0]   DecayRecip = 18'd104858;
  localparam logic [MulW-1:0]   DecayBias  = 18'd4;
  localparam logic [ProdW-1:0]  RoundHalf  = 36'd32768;

  typedef enum logic [CfgAddrW-1:0] {
    CfgCalibrated = 3'd0,
    CfgBaseLeft   = 3'd1,
    CfgBaseRight  = 3'd2,
    CfgGain       = 3'd3,
    CfgLimit      = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    DivLeft  = 2'd0,
    DivRight = 2'd1,
    DivAsym  = 2'd2
  } div_sel_e;

  typedef enum logic {
    LvlInt  = 1'b0,
    LvlAsym = 1'b1
  } lvl_sel_e;

  typedef struct packed {
    logic              calibrated;
    logic [CoordW-1:0] base_left;
    logic [CoordW-1:0] base_right;
    logic [CoordW-1:0] gain;
    logic [CoordW-1:0] limit;
  } cfg_t;

  typedef struct packed {
    logic     load;
    logic     div_init;
    logic     div_step;
    logic     div_store;
    div_sel_e div_sel;
    logic     mix;
    logic     mul;
    logic     wb;
    lvl_sel_e lvl_sel;
    logic     load_out;
  } cmd_t;

endpackage

/* hw/rtl/mcas_dp.sv */
// datapath: item registers, shared radix-4 divider, shared multiplier, levels
// depends on mcas_pkg and assert_macros.svh
`include "assert_macros.svh"
module mcas_dp #(
  parameter int COORD_WIDTH = mcas_pkg::DefCoordWidth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mcas_pkg::cfg_t              cfg_i,
  input  mcas_pkg::cmd_t              cmd_i,
  input  logic                        present_i,
  input  logic [mcas_pkg::CoordW-1:0] left_i,
  input  logic [mcas_pkg::CoordW-1:0] right_i,
  input  logic [mcas_pkg::CoordW-1:0] dist_i,
  output logic                        active_o,
  output logic [mcas_pkg::IntW-1:0]   intensity_o,
  output logic [mcas_pkg::AsymW-1:0]  asymmetry_o,
  output logic                        over_o
);
  import mcas_pkg::*;

  localparam int CoordBits = (COORD_WIDTH < CoordW) ? COORD_WIDTH : CoordW;
  localparam logic [CoordW-1:0] CoordMask = CoordW'((64'd1 << CoordBits) - 64'd1);

  logic [CoordW-1:0] lh_q, rh_q, dist_q, dist_m;
  logic              active_q;
  logic [CoordW-1:0] rem_q, num_q, den_q, quo_q;
  logic              sat_q, neg_q;
  logic [IntW-1:0]   lm_q, rm_q, mean_q;
  logic              ln_q, rn_q;
  logic [CoordW-1:0] diff_q;
  logic [AsymW-1:0]  asym_q;
  logic [ProdW-1:0]  prod_q;
  logic [IntW-1:0]   int_lvl_q;
  logic [AsymW-1:0]  asy_lvl_q;
  logic [IntW-1:0]   out_int_q;
  logic [AsymW-1:0]  out_asym_q;
  logic              out_over_q;

  logic [CoordW-1:0] base_m, cur_m, rise_mag;
  logic              rise_neg;
  logic [CoordW-1:0] r0, num0, den0;
  logic [CoordW:0]   s1, s2;
  logic              g1, g2;
  logic [CoordW-1:0] r1, r2;
  logic [IntW-1:0]   q15;
  logic [CoordW:0]   lr_sum;
  logic [CoordW-1:0] lvl_cur, x_cur, lvl_new;
  logic [MulW-1:0]   mul_a, mul_b;
  logic [ProdW-1:0]  acc;

  assign dist_m = dist_i & CoordMask;

  // rise of the selected corner above its baseline
  always_comb begin
    base_m   = ((cmd_i.div_sel == DivRight) ? cfg_i.base_right : cfg_i.base_left) & CoordMask;
    cur_m    = (cmd_i.div_sel == DivRight) ? rh_q : lh_q;
    rise_neg = cur_m > base_m;
    rise_mag = rise_neg ? (cur_m - base_m) : (base_m - cur_m);
    case (cmd_i.div_sel)
      DivLeft, DivRight: begin
        r0   = {3'b000, rise_mag[CoordW-1:3]};
        num0 = {rise_mag[2:0], 13'd0};
        den0 = dist_q;
      end
      DivAsym: begin
        r0   = {1'b0, diff_q[CoordW-1:1]};
        num0 = {diff_q[0], 15'd0};
        den0 = {1'b0, mean_q};
      end
      default: begin
        r0   = '0;
        num0 = '0;
        den0 = '0;
      end
    endcase
  end

  // two restoring steps per cycle
  always_comb begin
    s1 = {rem_q, num_q[CoordW-1]};
    g1 = s1 >= {1'b0, den_q};
    r1 = g1 ? CoordW'(s1 - {1'b0, den_q}) : s1[CoordW-1:0];
    s2 = {r1, num_q[CoordW-2]};
    g2 = s2 >= {1'b0, den_q};
    r2 = g2 ? CoordW'(s2 - {1'b0, den_q}) : s2[CoordW-1:0];
  end

  assign q15    = quo_q[CoordW-1:1];
  assign lr_sum = {2'b00, lm_q} + {2'b00, rm_q};

  // smoothing as level + g * (x - level), decay as level - ceil(level / 5)
  always_comb begin
    lvl_cur = (cmd_i.lvl_sel == LvlAsym) ? asy_lvl_q : {1'b0, int_lvl_q};
    x_cur   = (cmd_i.lvl_sel == LvlAsym) ? asym_q : {1'b0, mean_q};
    if (active_q) begin
      mul_a = {2'b00, cfg_i.gain};
      mul_b = {2'b00, x_cur} - {2'b00, lvl_cur};
    end else begin
      mul_a = DecayRecip;
      mul_b = {2'b00, lvl_cur} + DecayBias;
    end
    acc = {4'd0, lvl_cur, 16'd0} + prod_q + RoundHalf;
    if (active_q) begin
      lvl_new = acc[31:16];
    end else begin
      lvl_new = lvl_cur - prod_q[DecayShift +: CoordW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      lh_q     <= left_i & CoordMask;
      rh_q     <= right_i & CoordMask;
      dist_q   <= (dist_m < DistMin) ? DistMin : dist_m;
      active_q <= cfg_i.calibrated & present_i;
    end
    if (cmd_i.div_init) begin
      rem_q <= r0;
      num_q <= num0;
      den_q <= den0;
      quo_q <= '0;
      sat_q <= !(r0 < den0);
      neg_q <= rise_neg;
    end else if (cmd_i.div_step) begin
      rem_q <= r2;
      num_q <= {num_q[CoordW-3:0], 2'b00};
      quo_q <= {quo_q[CoordW-3:0], g1, g2};
    end
    if (cmd_i.div_store) begin
      case (cmd_i.div_sel)
        DivLeft: begin
          lm_q <= sat_q ? RiseSat : q15;
          ln_q <= neg_q & (sat_q | (q15 != '0));
        end
        DivRight: begin
          rm_q <= sat_q ? RiseSat : q15;
          rn_q <= neg_q & (sat_q | (q15 != '0));
        end
        default: begin
          if (mean_q == '0) begin
            asym_q <= '0;
          end else begin
            asym_q <= sat_q ? AsymSat : {1'b0, q15};
          end
        end
      endcase
    end
    if (cmd_i.mix) begin
      mean_q <= lr_sum[IntW:1];
      if (ln_q == rn_q) begin
        diff_q <= (lm_q >= rm_q) ? {1'b0, lm_q - rm_q} : {1'b0, rm_q - lm_q};
      end else begin
        diff_q <= lr_sum[CoordW-1:0];
      end
    end
    if (cmd_i.mul) begin
      prod_q <= ProdW'($signed(mul_a) * $signed(mul_b));
    end
    if (cmd_i.load_out) begin
      out_int_q  <= int_lvl_q;
      out_asym_q <= asy_lvl_q;
      out_over_q <= asy_lvl_q > cfg_i.limit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      int_lvl_q <= '0;
      asy_lvl_q <= '0;
    end else if (cmd_i.wb) begin
      if (cmd_i.lvl_sel == LvlAsym) begin
        asy_lvl_q <= lvl_new;
      end else begin
        int_lvl_q <= lvl_new[IntW-1:0];
      end
    end
  end

  assign active_o    = active_q;
  assign intensity_o = out_int_q;
  assign asymmetry_o = out_asym_q;
  assign over_o      = out_over_q;

  `MCAS_ASSERT(a_div_rem_below_den, (cmd_i.div_step && !sat_q) |-> (rem_q < den_q))

endmodule

/* hw/rtl/mcas_ctrl.sv */
// controller: load, 3 divisions + mix if active, two level updates, output
// depends on mcas_pkg and assert_macros.svh
`include "assert_macros.svh"
module mcas_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_valid_i,
  output logic           s_ready_o,
  output logic           m_valid_o,
  input  logic           m_ready_i,
  input  logic           active_i,
  output mcas_pkg::cmd_t cmd_o
);
  import mcas_pkg::*;

  typedef enum logic [7:0] {
    StIdle  = 8'b0000_0001,
    StInit  = 8'b0000_0010,
    StDiv   = 8'b0000_0100,
    StStore = 8'b0000_1000,
    StMix   = 8'b0001_0000,
    StMul   = 8'b0010_0000,
    StWb    = 8'b0100_0000,
    StDone  = 8'b1000_0000
  } state_e;

  state_e             state_q, state_d;
  div_sel_e           sel_q, sel_d;
  lvl_sel_e           lvl_q, lvl_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  cmd_t               cmd;

  always_comb begin
    state_d      = state_q;
    sel_d        = sel_q;
    lvl_d        = lvl_q;
    cnt_d        = cnt_q;
    cmd          = '0;
    cmd.div_sel  = sel_q;
    cmd.lvl_sel  = lvl_q;
    case (state_q)
      StIdle: begin
        if (s_valid_i) begin
          cmd.load = 1'b1;
          sel_d    = DivLeft;
          lvl_d    = LvlInt;
          state_d  = StInit;
        end
      end
      StInit: begin
        if (active_i) begin
          cmd.div_init = 1'b1;
          cnt_d        = '0;
          state_d      = StDiv;
        end else begin
          state_d = StMul;
        end
      end
      StDiv: begin
        cmd.div_step = 1'b1;
        cnt_d        = cnt_q + 1'b1;
        if (cnt_q == DivCntW'(DivSteps - 1)) begin
          state_d = StStore;
        end
      end
      StStore: begin
        cmd.div_store = 1'b1;
        case (sel_q)
          DivLeft: begin
            sel_d   = DivRight;
            state_d = StInit;
          end
          DivRight: state_d = StMix;
          default:  state_d = StMul;
        endcase
      end
      StMix: begin
        cmd.mix = 1'b1;
        sel_d   = DivAsym;
        state_d = StInit;
      end
      StMul: begin
        cmd.mul = 1'b1;
        state_d = StWb;
      end
      StWb: begin
        cmd.wb = 1'b1;
        if (lvl_q == LvlInt) begin
          lvl_d   = LvlAsym;
          state_d = StMul;
        end else begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (!out_valid_q || m_ready_i) begin
          cmd.load_out = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      sel_q       <= DivLeft;
      lvl_q       <= LvlInt;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sel_q       <= sel_d;
      lvl_q       <= lvl_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign s_ready_o = (state_q == StIdle);
  assign m_valid_o = out_valid_q;
  assign cmd_o     = cmd;

  `MCAS_ASSERT(a_state_onehot, $onehot(state_q))
  `MCAS_NEVER(a_no_overwrite, cmd.load_out && out_valid_q && !m_ready_i)
  `MCAS_ASSERT(a_store_after_div,
               (state_q == StStore) |->
               ($past(state_q) == StDiv && $past(cnt_q) == DivCntW'(DivSteps - 1)))

endmodule

/* hw/rtl/mouth_corner_asymmetry_smoother.sv */
// mouth corner asymmetry smoother, top level with configuration registers
// depends on mcas_pkg, mcas_ctrl and mcas_dp
//
// one input transaction per frame: mouth corner heights and eye distance in
// tdata, corners present flag in tuser. one output transaction per input:
// smoothed intensity and asymmetry in tdata, over limit flag in tuser.
// configuration: cfg_we_i writes cfg_data_i to register cfg_addr_i; the user
// must write only while no frame is in flight, the block does not enforce it.
// with calibration and corners present, a frame goes through three serial
// divisions at two quotient bits per cycle, then two multiply and write back
// passes; otherwise through the two passes only. the next input is taken in
// the cycle after the output register loads, so no new frame is taken before
// the last one is done.
// a finished result waits in the output register while the next frame is
// taken and worked; a stalled receiver holds the block only when that frame
// is done too.
// reset clears both smoothed levels, the registers to their defaults and
// the output valid.
module mouth_corner_asymmetry_smoother #(
  parameter int COORD_WIDTH = mcas_pkg::DefCoordWidth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // left_height, right_height, eye_distance
  input  logic [mcas_pkg::InDataW-1:0]  s_axis_tdata,
  // corners_present
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // smooth_intensity, smooth_asymmetry, one zero pad bit
  output logic [mcas_pkg::OutDataW-1:0] m_axis_tdata,
  // over_limit
  output logic                          m_axis_tuser,
  input  logic                          cfg_we_i,
  input  logic [mcas_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [mcas_pkg::CfgDataW-1:0] cfg_data_i
);
  import mcas_pkg::*;

  cfg_t             cfg_q;
  cmd_t             cmd;
  logic             active;
  logic [IntW-1:0]  intensity;
  logic [AsymW-1:0] asymmetry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.calibrated <= 1'b0;
      cfg_q.base_left  <= '0;
      cfg_q.base_right <= '0;
      cfg_q.gain       <= GainReset;
      cfg_q.limit      <= LimitReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CfgCalibrated: cfg_q.calibrated <= cfg_data_i[0];
        CfgBaseLeft:   cfg_q.base_left  <= cfg_data_i;
        CfgBaseRight:  cfg_q.base_right <= cfg_data_i;
        CfgGain:       cfg_q.gain       <= cfg_data_i;
        CfgLimit:      cfg_q.limit      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mcas_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .active_i  (active),
    .cmd_o     (cmd)
  );

  mcas_dp #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (cmd),
    .present_i   (s_axis_tuser),
    .left_i      (s_axis_tdata[15:0]),
    .right_i     (s_axis_tdata[31:16]),
    .dist_i      (s_axis_tdata[47:32]),
    .active_o    (active),
    .intensity_o (intensity),
    .asymmetry_o (asymmetry),
    .over_o      (m_axis_tuser)
  );

  assign m_axis_tdata = {1'b0, asymmetry, intensity};

endmodule

/* tb/tb_top.sv */
// testbench for mouth_corner_asymmetry_smoother: streams landmark frames with
// random bursts and receiver stalls, predicts both smoothed levels in a small
// scoreboard class and checks every result; depends on mcas_pkg and the rtl
module tb_top;
  import mcas_pkg::*;

  typedef struct packed {
    logic [IntW-1:0]  intensity;
    logic [AsymW-1:0] asymmetry;
    logic             over_limit;
  } levels_t;

  typedef enum int {RxAlways, RxCoin, RxSparse, RxPeriodic} rx_mode_e;

  class smoother_scoreboard;
    logic              calibrated = 1'b0;
    logic [CoordW-1:0] base_left = '0;
    logic [CoordW-1:0] base_right = '0;
    logic [CoordW-1:0] gain = GainReset;
    logic [CoordW-1:0] limit = LimitReset;
    logic [IntW-1:0]   intensity_level = '0;
    logic [AsymW-1:0]  asymmetry_level = '0;
    levels_t           expected_levels[$];
    int                errors = 0;
    int                checked = 0;

    function void write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] val);
      case (idx)
        CfgCalibrated: calibrated = val[0];
        CfgBaseLeft:   base_left = val;
        CfgBaseRight:  base_right = val;
        CfgGain:       gain = val;
        CfgLimit:      limit = val;
        default: ;
      endcase
    endfunction

    // signed q3.12 rise of one corner as magnitude and sign
    function void corner_rise(input logic [CoordW-1:0] base, cur,
                              input logic [63:0] eye_dist,
                              output logic [63:0] mag, output logic neg);
      if (base >= cur) begin
        mag = 64'(base) - 64'(cur);
        neg = 1'b0;
      end else begin
        mag = 64'(cur) - 64'(base);
        neg = 1'b1;
      end
      mag = (mag << 12) / eye_dist;
      if (mag > 64'd32767) mag = 64'd32767;
      if (mag == 64'd0) neg = 1'b0;
    endfunction

    function logic [63:0] blend_level(logic [63:0] level, logic [63:0] sample);
      logic [63:0] g;
      g = 64'(gain);
      return ((64'd65536 - g) * level + g * sample + 64'd32768) >> 16;
    endfunction

    function void note_frame(logic present, logic [CoordW-1:0] lh, rh, eye_dist);
      logic [63:0] d, lm, rm, mean, diff, asym;
      logic        ln, rn;
      levels_t     lv;
      if (calibrated && present) begin
        d = (eye_dist < DistMin) ? 64'(DistMin) : 64'(eye_dist);
        corner_rise(base_left, lh, d, lm, ln);
        corner_rise(base_right, rh, d, rm, rn);
        mean = (lm + rm) >> 1;
        if (ln == rn) diff = (lm >= rm) ? lm - rm : rm - lm;
        else diff = lm + rm;
        if (mean == 64'd0) begin
          asym = 64'd0;
        end else begin
          asym = (diff << 14) / mean;
          if (asym > 64'd32768) asym = 64'd32768;
        end
        intensity_level = IntW'(blend_level(64'(intensity_level), mean));
        asymmetry_level = AsymW'(blend_level(64'(asymmetry_level), asym));
      end else begin
        intensity_level = IntW'((64'(intensity_level) * 64'd4) / 64'd5);
        asymmetry_level = AsymW'((64'(asymmetry_level) * 64'd4) / 64'd5);
      end
      lv.intensity  = intensity_level;
      lv.asymmetry  = asymmetry_level;
      lv.over_limit = asymmetry_level > limit;
      expected_levels.push_back(lv);
    endfunction

    function void check_result(logic [OutDataW-1:0] data, logic flag);
      levels_t lv;
      if (expected_levels.size() == 0) begin
        $error("result transaction with no frame pending: tdata %h", data);
        errors++;
        return;
      end
      lv = expected_levels.pop_front();
      checked++;
      if (data[IntW-1:0] !== lv.intensity) begin
        $error("smooth_intensity: expected %0d, got %0d", lv.intensity, data[IntW-1:0]);
        errors++;
      end
      if (data[IntW+AsymW-1:IntW] !== lv.asymmetry) begin
        $error("smooth_asymmetry: expected %0d, got %0d", lv.asymmetry,
               data[IntW+AsymW-1:IntW]);
        errors++;
      end
      if (flag !== lv.over_limit) begin
        $error("over_limit: expected %0d, got %0d", lv.over_limit, flag);
        errors++;
      end
    endfunction

    function int pending();
      return expected_levels.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;
  logic                cfg_we_i;
  logic [CfgAddrW-1:0] cfg_addr_i;
  logic [CfgDataW-1:0] cfg_data_i;

  smoother_scoreboard board;
  int                 frames_sent = 0;
  int                 settings_used = 0;
  int                 burst_left = 0;
  bit                 gaps_on = 1'b1;
  int                 rx_cycle = 0;
  int                 hold_left = 0;
  rx_mode_e           rx_mode = RxAlways;

  mouth_corner_asymmetry_smoother dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // receiver stall pattern, with long hold-offs to back up the input
  always @(negedge clk_i) begin
    rx_cycle++;
    if (rx_cycle == 2500 || rx_cycle == 15000) hold_left = 400;
    if (rx_cycle % 200 == 0) rx_mode = rx_mode_e'($urandom_range(0, 3));
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RxAlways:   m_axis_tready <= 1'b1;
        RxCoin:     m_axis_tready <= 1'($urandom_range(0, 1));
        RxSparse:   m_axis_tready <= ($urandom_range(0, 3) == 0);
        RxPeriodic: m_axis_tready <= rx_cycle[3];
        default:    m_axis_tready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata, m_axis_tuser);
  end

  task automatic set_config(logic cal, logic [CoordW-1:0] bl, br, g, lim);
    cfg_idx_e             idx[5];
    logic [CfgDataW-1:0]  val[5];
    idx = '{CfgCalibrated, CfgBaseLeft, CfgBaseRight, CfgGain, CfgLimit};
    val = '{CfgDataW'(cal), bl, br, g, lim};
    for (int i = 0; i < 5; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_addr_i <= idx[i];
      cfg_data_i <= val[i];
      board.write_reg(idx[i], val[i]);
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    settings_used++;
  endtask

  task automatic send_frame(logic present, logic [CoordW-1:0] lh, rh, eye_dist);
    if (gaps_on && burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {eye_dist, rh, lh};
    s_axis_tuser  <= present;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_frame(present, lh, rh, eye_dist);
    frames_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [CoordW-1:0] near_base(logic [CoordW-1:0] base, int span);
    logic [CoordW-1:0] off;
    off = CoordW'($urandom_range(0, span));
    return $urandom_range(0, 1) ? base + off : base - off;
  endfunction

  task automatic send_random_frame();
    logic [CoordW-1:0] lh, rh, eye_dist;
    int                pick;
    pick = $urandom_range(0, 9);
    if (pick < 2) begin
      lh = CoordW'($urandom);
      rh = CoordW'($urandom);
    end else if (pick == 9) begin
      lh = board.base_left;
      rh = board.base_right;
    end else begin
      lh = near_base(board.base_left, (pick < 6) ? 255 : 4095);
      rh = near_base(board.base_right, (pick < 6) ? 255 : 4095);
    end
    pick = $urandom_range(0, 9);
    if (pick == 0) eye_dist = CoordW'($urandom_range(0, 31));
    else if (pick < 3) eye_dist = CoordW'($urandom);
    else eye_dist = CoordW'($urandom_range(128, 4096));
    send_frame($urandom_range(0, 9) != 0, lh, rh, eye_dist);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  initial begin
    logic              cal;
    logic [CoordW-1:0] bl, br, g, lim;
    board         = new;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = CfgCalibrated;
    cfg_data_i    = '0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // defaults: not calibrated, levels only decay
    send_frame(1'b1, 16'h1234, 16'h4321, 16'h0400);
    send_frame(1'b0, 16'h0000, 16'hffff, 16'h0000);
    wait_idle();

    set_config(1'b1, 16'h8000, 16'h8000, 16'hffff, 16'd0);
    send_frame(1'b1, 16'h8000, 16'h8000, 16'h0100);
    send_frame(1'b1, 16'h0000, 16'h0000, 16'h0000);
    send_frame(1'b1, 16'hffff, 16'hffff, 16'h000f);
    send_frame(1'b1, 16'h0000, 16'hffff, 16'h0010);
    send_frame(1'b1, 16'h7f00, 16'h8000, 16'hffff);
    send_frame(1'b1, 16'h7ff0, 16'h7fe0, 16'h0400);
    send_frame(1'b0, 16'h7ff0, 16'h7fe0, 16'h0400);
    send_frame(1'b1, 16'h8010, 16'h7ff0, 16'h0200);
    send_frame(1'b1, 16'hffff, 16'h0000, 16'hffff);
    wait_idle();

    set_config(1'b1, 16'h0000, 16'hffff, 16'd0, AsymSat);
    send_frame(1'b1, 16'h0000, 16'hffff, 16'h0100);
    send_frame(1'b1, 16'hffff, 16'h0000, 16'h0000);
    wait_idle();

    set_config(1'b1, 16'h0000, 16'hffff, 16'd32768, AsymSat);
    send_frame(1'b1, 16'hffff, 16'h0000, 16'h0000);
    send_frame(1'b1, 16'h0040, 16'hff00, 16'h0020);
    wait_idle();

    set_config(1'b0, 16'h0000, 16'hffff, 16'd32768, 16'd0);
    send_frame(1'b1, 16'h0040, 16'hff00, 16'h0020);
    send_frame(1'b1, 16'h0040, 16'hff00, 16'h0020);
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin g = 16'hffff; lim = 16'd0; end
        1: begin g = GainReset; lim = AsymSat; end
        2: begin g = 16'd0; lim = LimitReset; end
        3: begin g = 16'd1; lim = AsymSat; end
        default: begin
          g   = CoordW'($urandom);
          lim = CoordW'($urandom_range(0, 32768));
        end
      endcase
      bl  = (p == 1) ? 16'h0000 : (p == 4) ? 16'hffff : CoordW'($urandom);
      br  = (p == 1) ? 16'hffff : (p == 4) ? 16'h0000 : CoordW'($urandom);
      cal = (p != 5);
      gaps_on = (p % 2 == 0);
      set_config(cal, bl, br, g, lim);
      repeat (200) send_random_frame();
      wait_idle();
    end

    $display("%0d frames over %0d register settings, %0d results checked",
             frames_sent, settings_used, board.checked);
    if (board.pending() != 0) begin
      $error("%0d expected results never arrived", board.pending());
      board.errors++;
    end
    if (board.errors == 0) begin
      $display("mouth_corner_asymmetry_smoother: match");
    end else begin
      $display("mouth_corner_asymmetry_smoother: mismatch");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d results outstanding", board.pending());
    $display("mouth_corner_asymmetry_smoother: mismatch");
    $finish;
  end

endmodule
